// ===== rtl/nsfb_pkg.sv =====
// Package for the nerve stimulation filter bank: word types, register map,
// reset values and the microcode program of the sequencer. No dependencies.
`timescale 1ns / 1ps

package nsfb_pkg;

  // Input and result words
  typedef struct packed {
    logic signed [15:0] grad_sample;
    logic               waveform_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] stim_first;
    logic signed [31:0] stim_second;
    logic signed [31:0] stim_third;
  } out_t;

  // Register map (index = paddr[4:2])
  localparam logic [2:0] REG_ALPHA_FIRST  = 3'd0;
  localparam logic [2:0] REG_ALPHA_SECOND = 3'd1;
  localparam logic [2:0] REG_ALPHA_THIRD  = 3'd2;
  localparam logic [2:0] REG_GAIN_FIRST   = 3'd3;
  localparam logic [2:0] REG_GAIN_SECOND  = 3'd4;
  localparam logic [2:0] REG_GAIN_THIRD   = 3'd5;
  localparam logic [2:0] REG_ABS_MODE     = 3'd6;

  localparam logic [15:0] ALPHA_FIRST_RST  = 16'd3121;
  localparam logic [15:0] ALPHA_SECOND_RST = 16'd16384;
  localparam logic [15:0] ALPHA_THIRD_RST  = 16'd218;

  localparam int unsigned FILT_W = 34;

  // Filter select codes
  localparam logic [1:0] FILT_FIRST  = 2'd0;
  localparam logic [1:0] FILT_SECOND = 2'd1;
  localparam logic [1:0] FILT_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_e;

  // One control word per step
  typedef struct packed {
    jump_e      jump;
    logic       mul_en;
    logic       mul_gain;  // 0: filter coefficient product, 1: output gain product
    logic [1:0] mul_idx;
    logic       upd_en;
    logic [1:0] upd_idx;
    logic       sat_en;
    logic [1:0] sat_idx;
  } ctrl_t;

  localparam int unsigned NUM_STEPS = 8;
  localparam logic [2:0]  LAST_STEP = 3'(NUM_STEPS - 1);

  localparam ctrl_t UCODE [NUM_STEPS] = '{
    '{JMP_WAIT_IN,  1'b0, 1'b0, FILT_FIRST,  1'b0, FILT_FIRST,  1'b0, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b0, FILT_FIRST,  1'b0, FILT_FIRST,  1'b0, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b0, FILT_SECOND, 1'b1, FILT_FIRST,  1'b0, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b0, FILT_THIRD,  1'b1, FILT_SECOND, 1'b0, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b1, FILT_FIRST,  1'b1, FILT_THIRD,  1'b0, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b1, FILT_SECOND, 1'b0, FILT_FIRST,  1'b1, FILT_FIRST},
    '{JMP_NEXT,     1'b1, 1'b1, FILT_THIRD,  1'b0, FILT_FIRST,  1'b1, FILT_SECOND},
    '{JMP_WAIT_OUT, 1'b0, 1'b0, FILT_FIRST,  1'b0, FILT_FIRST,  1'b1, FILT_THIRD}
  };

endpackage

// ===== rtl/nerve_stimulation_filter_bank_core.sv =====
// Sequencing: a new input word is taken only after the last result is loaded:
// an accept cycle plus seven microcode steps, set by the single shared 33x32
// multiplier (six products per word); the last step waits for a free result slot.
// Reset: asynchronous, active low; clears the step counter, the result slot,
// previous sample and filter states, and loads the register reset values.
// Top level of the filter bank; depends on nsfb_pkg.
`timescale 1ns / 1ps

module nerve_stimulation_filter_bank_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nsfb_pkg::in_t       in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nsfb_pkg::out_t      out_data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import nsfb_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [15:0] alpha0_q, alpha1_q, alpha2_q;
  logic [31:0] gain0_q, gain1_q, gain2_q;
  logic        abs_mode_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha0_q   <= ALPHA_FIRST_RST;
      alpha1_q   <= ALPHA_SECOND_RST;
      alpha2_q   <= ALPHA_THIRD_RST;
      gain0_q    <= '0;
      gain1_q    <= '0;
      gain2_q    <= '0;
      abs_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ALPHA_FIRST:  alpha0_q   <= pwdata[15:0];
        REG_ALPHA_SECOND: alpha1_q   <= pwdata[15:0];
        REG_ALPHA_THIRD:  alpha2_q   <= pwdata[15:0];
        REG_GAIN_FIRST:   gain0_q    <= pwdata;
        REG_GAIN_SECOND:  gain1_q    <= pwdata;
        REG_GAIN_THIRD:   gain2_q    <= pwdata;
        REG_ABS_MODE:     abs_mode_q <= pwdata[0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ALPHA_FIRST:  prdata = {16'h0, alpha0_q};
      REG_ALPHA_SECOND: prdata = {16'h0, alpha1_q};
      REG_ALPHA_THIRD:  prdata = {16'h0, alpha2_q};
      REG_GAIN_FIRST:   prdata = gain0_q;
      REG_GAIN_SECOND:  prdata = gain1_q;
      REG_GAIN_THIRD:   prdata = gain2_q;
      REG_ABS_MODE:     prdata = {31'h0, abs_mode_q};
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: step counter addresses the microcode table
  // ------------------------------------------------------------------
  logic [2:0] pc_q, pc_d;
  ctrl_t      uc;
  logic       in_acc;
  logic       slot_free;
  logic       out_load;

  assign uc         = UCODE[pc_q];
  assign in_ready_o = (uc.jump == JMP_WAIT_IN);
  assign in_acc     = in_valid_i && in_ready_o;
  // The result slot can take a new word when empty or being drained now.
  assign slot_free  = !out_valid_o || out_ready_i;
  assign out_load   = (uc.jump == JMP_WAIT_OUT) && slot_free;

  always_comb begin
    pc_d = pc_q;
    case (uc.jump)
      JMP_NEXT:     pc_d = pc_q + 3'd1;
      JMP_WAIT_IN:  if (in_valid_i) pc_d = pc_q + 3'd1;
      JMP_WAIT_OUT: if (slot_free) pc_d = '0;
      default:      pc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  // ------------------------------------------------------------------
  // Slew and filter state
  // ------------------------------------------------------------------
  logic signed [15:0]       prev_q;
  logic signed [16:0]       slew_q, slew_d;
  logic signed [FILT_W-1:0] filt0_q, filt1_q, filt2_q;
  logic signed [16:0]       slew_abs;

  // A start word treats the previous sample as zero.
  assign slew_d   = {in_data_i.grad_sample[15], in_data_i.grad_sample}
                  - (in_data_i.waveform_start ? 17'sd0 : {prev_q[15], prev_q});
  assign slew_abs = slew_q[16] ? -slew_q : slew_q;

  // Per-filter selection
  logic signed [FILT_W-1:0] mul_filt, upd_filt;
  logic [15:0]              mul_alpha;
  logic [31:0]              mul_gain;
  logic signed [16:0]       mul_x;

  always_comb begin
    case (uc.mul_idx)
      FILT_SECOND: begin
        mul_filt  = filt1_q;
        mul_alpha = alpha1_q;
        mul_gain  = gain1_q;
        mul_x     = slew_abs;
      end
      FILT_THIRD: begin
        mul_filt  = filt2_q;
        mul_alpha = alpha2_q;
        mul_gain  = gain2_q;
        mul_x     = slew_q;
      end
      default: begin
        mul_filt  = filt0_q;
        mul_alpha = alpha0_q;
        mul_gain  = gain0_q;
        mul_x     = slew_q;
      end
    endcase
    case (uc.upd_idx)
      FILT_SECOND: upd_filt = filt1_q;
      FILT_THIRD:  upd_filt = filt2_q;
      default:     upd_filt = filt0_q;
    endcase
  end

  // ------------------------------------------------------------------
  // Shared multiplier: |operand| * coefficient, sign carried aside
  // ------------------------------------------------------------------
  logic signed [FILT_W-1:0] x_ext, x_q16;
  logic signed [FILT_W:0]   d_full;
  logic [FILT_W:0]          d_mag;
  logic [FILT_W-1:0]        f_mag;
  logic [32:0]              mul_a;
  logic [31:0]              mul_b;
  logic [64:0]              mul_p;
  logic                     mul_neg;
  logic [63:0]              prod_q;
  logic                     neg_q;

  assign x_ext  = {{(FILT_W - 17){mul_x[16]}}, mul_x};
  assign x_q16  = x_ext <<< 16;
  // Target minus state; the state stays within 33 bits so this fits 35.
  assign d_full = {x_q16[FILT_W-1], x_q16} - {mul_filt[FILT_W-1], mul_filt};
  assign d_mag  = d_full[FILT_W] ? -d_full : d_full;
  assign f_mag  = mul_filt[FILT_W-1] ? -mul_filt : mul_filt;

  always_comb begin
    if (uc.mul_gain) begin
      mul_a = {1'b0, f_mag[31:0]};
      mul_b = mul_gain;
      if (abs_mode_q) begin
        mul_neg = 1'b0;
      end else if (uc.mul_idx == FILT_SECOND) begin
        mul_neg = slew_q[16];  // zero slew counts as positive
      end else begin
        mul_neg = mul_filt[FILT_W-1];
      end
    end else begin
      mul_a   = d_mag[32:0];
      mul_b   = {16'h0, mul_alpha};
      mul_neg = d_full[FILT_W];
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (uc.mul_en) begin
      prod_q <= mul_p[63:0];
      neg_q  <= mul_neg;
    end
  end

  // Floor of the signed product over 2^16: round the magnitude up when negative.
  logic [49:0]              ceil_sum;
  logic signed [FILT_W-1:0] incr, upd_next;

  assign ceil_sum = {1'b0, prod_q[48:0]} + 50'd65535;
  assign incr     = neg_q ? -FILT_W'(ceil_sum[49:16]) : FILT_W'(prod_q[48:16]);
  assign upd_next = upd_filt + incr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      slew_q  <= '0;
      filt0_q <= '0;
      filt1_q <= '0;
      filt2_q <= '0;
    end else if (in_acc) begin
      prev_q <= in_data_i.grad_sample;
      slew_q <= slew_d;
      if (in_data_i.waveform_start) begin
        filt0_q <= '0;
        filt1_q <= '0;
        filt2_q <= '0;
      end
    end else if (uc.upd_en) begin
      case (uc.upd_idx)
        FILT_SECOND: filt1_q <= upd_next;
        FILT_THIRD:  filt2_q <= upd_next;
        default:     filt0_q <= upd_next;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Scale and saturate: (|state| * gain) >> 24, then apply sign
  // ------------------------------------------------------------------
  logic [39:0]        q_mag;
  logic signed [31:0] sat_val;
  logic signed [31:0] res0_q, res1_q;

  assign q_mag = prod_q[63:24];

  always_comb begin
    if (neg_q) begin
      sat_val = (q_mag > 40'h0080000000) ? 32'sh80000000 : -$signed(q_mag[31:0]);
    end else begin
      sat_val = (q_mag > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(q_mag[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.sat_en) begin
      case (uc.sat_idx)
        FILT_FIRST:  res0_q <= sat_val;
        FILT_SECOND: res1_q <= sat_val;
        default: ;  // third result goes straight to the output slot
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Output slot: hold the word until taken
  // ------------------------------------------------------------------
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.stim_first  <= res0_q;
      out_q.stim_second <= res1_q;
      out_q.stim_third  <= sat_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts_program : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pc_q == 3'd1)
    else $error("program did not start after an accepted word");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == LAST_STEP) && out_valid_o && !out_ready_i |=> pc_q == LAST_STEP)
    else $error("last step left while the result slot was full");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result load did not raise out_valid_o");

  a_filter_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filt0_q[FILT_W-1] == filt0_q[FILT_W-2]) && (filt1_q[FILT_W-1] == filt1_q[FILT_W-2])
    && (filt2_q[FILT_W-1] == filt2_q[FILT_W-2]))
    else $error("filter state left its 33-bit range");
`endif

endmodule

// ===== test/tb_nerve_stimulation_filter_bank_core.sv =====
// Self-checking testbench for nerve_stimulation_filter_bank_core: directed table, then
// random waveforms; results compared with hand-written values or a built-in predictor.
// Depends on nsfb_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_nerve_stimulation_filter_bank_core;
  import nsfb_pkg::*;

  localparam int          TOTAL_WORDS  = 1450;
  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;
  localparam logic [31:0] STIM_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] STIM_MIN     = 32'h8000_0000;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // One line of the directed table: either a register write or an input word,
  // the latter optionally with a hand-written expected result.
  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_t         word;
    bit          typed;
    out_t        stim;
  } dir_row_t;

  // Block I/O
  logic        clk_i;
  logic        rst_n       = 1'b0;
  logic        in_valid_q  = 1'b0;
  in_t         in_data_q   = '0;
  logic        out_ready_q = 1'b0;
  logic        psel_q      = 1'b0;
  logic        penable_q   = 1'b0;
  logic        pwrite_q    = 1'b0;
  logic [4:0]  paddr_q     = '0;
  logic [31:0] pwdata_q    = '0;
  logic        in_ready;
  logic        out_valid;
  out_t        out_data;
  logic [31:0] apb_prdata;
  logic        apb_pready;

  // Predictor copy of the configuration and filter state
  logic [15:0]        cfg_alpha [3] = '{ALPHA_FIRST_RST, ALPHA_SECOND_RST, ALPHA_THIRD_RST};
  logic [31:0]        cfg_gain  [3] = '{32'd0, 32'd0, 32'd0};
  logic               cfg_abs       = 1'b0;
  logic signed [15:0] prev_sample_q = '0;
  logic signed [33:0] lp_state  [3] = '{34'sd0, 34'sd0, 34'sd0};

  out_t       stim_expected [$];
  dir_row_t   dir_rows [$];
  idle_mode_e tx_idle = IDLE_FULL;
  idle_mode_e rx_idle = IDLE_SPARSE;
  int         mismatch_cnt = 0;
  int         words_sent   = 0;
  int         results_seen = 0;
  int         cycle_cnt    = 0;

  nerve_stimulation_filter_bank_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_q),
    .out_data_o  (out_data),
    .psel        (psel_q),
    .penable     (penable_q),
    .pwrite      (pwrite_q),
    .paddr       (paddr_q),
    .pwdata      (pwdata_q),
    .prdata      (apb_prdata),
    .pready      (apb_pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One low-pass step: acc += floor(coef * (target * 2^16 - acc) / 2^16).
  // The arithmetic shift of a signed product is exactly that floor.
  function automatic logic signed [33:0] lowpass_next(logic signed [33:0] acc,
                                                      logic [15:0] coef,
                                                      logic signed [16:0] target);
    longint diff;
    longint prod;
    diff = longint'(target) * 64'sd65536 - longint'(acc);
    prod = longint'(coef) * diff;
    return 34'(longint'(acc) + (prod >>> 16));
  endfunction

  // |acc| * gain >> 24 (magnitude truncation), then sign and saturate to 32 bits.
  function automatic logic [31:0] stim_scale(logic signed [33:0] acc, logic [31:0] gain,
                                             bit neg);
    logic [33:0] mag;
    logic [65:0] prod;
    logic [41:0] q;
    mag  = acc[33] ? 34'(-acc) : 34'(acc);
    prod = 66'(mag) * 66'(gain);
    q    = prod[65:24];
    if (neg) return (q > 42'h0_8000_0000) ? STIM_MIN : 32'(-q);
    return (q > 42'h0_7FFF_FFFF) ? STIM_MAX : q[31:0];
  endfunction

  // Advance the predictor by one input word and return the stimulation result.
  function automatic out_t filter_bank_step(in_t w);
    logic signed [16:0] slew;
    logic signed [16:0] slew_mag;
    out_t               r;
    if (w.waveform_start) begin
      prev_sample_q = '0;
      lp_state      = '{34'sd0, 34'sd0, 34'sd0};
    end
    slew = $signed({w.grad_sample[15], w.grad_sample}) -
           $signed({prev_sample_q[15], prev_sample_q});
    prev_sample_q = w.grad_sample;
    slew_mag      = slew[16] ? -slew : slew;
    lp_state[0]   = lowpass_next(lp_state[0], cfg_alpha[0], slew);
    lp_state[1]   = lowpass_next(lp_state[1], cfg_alpha[1], slew_mag);
    lp_state[2]   = lowpass_next(lp_state[2], cfg_alpha[2], slew);
    // Zero slew counts as positive; abs mode forces every output non-negative.
    r.stim_first  = stim_scale(lp_state[0], cfg_gain[0], !cfg_abs && lp_state[0][33]);
    r.stim_second = stim_scale(lp_state[1], cfg_gain[1], !cfg_abs && slew[16]);
    r.stim_third  = stim_scale(lp_state[2], cfg_gain[2], !cfg_abs && lp_state[2][33]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
    dir_row_t row;
    row         = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, word: '0, typed: 1'b0,
                    stim: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_word(logic signed [15:0] sample, logic start);
    dir_row_t row;
    row = '{kind: ROW_WORD, reg_idx: '0, reg_val: '0,
            word: '{grad_sample: sample, waveform_start: start}, typed: 1'b0, stim: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic signed [15:0] sample, logic start,
                                    logic [31:0] f, logic [31:0] s, logic [31:0] t);
    dir_row_t row;
    row = '{kind: ROW_WORD, reg_idx: '0, reg_val: '0,
            word: '{grad_sample: sample, waveform_start: start}, typed: 1'b1,
            stim: '{stim_first: f, stim_second: s, stim_third: t}};
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers shared by stimulus and result side
  // ---------------------------------------------------------------------------

  function automatic int draw_wait(idle_mode_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 17)) : 0;
      default:     return int'($urandom_range(0, 17));
    endcase
  endfunction

  function automatic logic [31:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h0000_FFFF;
      2:       return $urandom;  // upper bits must be dropped by the register
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0200_0000);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // APB write: setup cycle, then access until pready; mirror into the predictor.
  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    bit rdy;
    psel_q    <= 1'b1;
    penable_q <= 1'b0;
    pwrite_q  <= 1'b1;
    paddr_q   <= {idx, 2'b00};
    pwdata_q  <= val;
    @(posedge clk_i);
    penable_q <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = apb_pready;
      @(posedge clk_i);
    end
    psel_q    <= 1'b0;
    penable_q <= 1'b0;
    pwrite_q  <= 1'b0;
    case (idx)
      REG_ALPHA_FIRST:  cfg_alpha[0] = val[15:0];
      REG_ALPHA_SECOND: cfg_alpha[1] = val[15:0];
      REG_ALPHA_THIRD:  cfg_alpha[2] = val[15:0];
      REG_GAIN_FIRST:   cfg_gain[0]  = val;
      REG_GAIN_SECOND:  cfg_gain[1]  = val;
      REG_GAIN_THIRD:   cfg_gain[2]  = val;
      REG_ABS_MODE:     cfg_abs      = val[0];
      default: ;  // unmapped index: the write has no effect
    endcase
    @(posedge clk_i);
  endtask

  // Offer one input word after a random gap; predict it on the accepting edge.
  // Handshakes are sampled at the falling edge, where every signal is settled.
  task automatic send_word(in_t w, bit typed, out_t typed_stim);
    int   gap;
    bit   taken;
    out_t pred;
    gap = draw_wait(tx_idle);
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    in_data_q  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready;
      @(posedge clk_i);
    end
    pred = filter_bank_step(w);
    stim_expected.push_back(typed ? typed_stim : pred);
    words_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has arrived.
  task automatic settle_block();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (stim_expected.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int   stall;
    bit   got;
    out_t seen;
    out_t want;
    wait (rst_n == 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(rx_idle);
      if (stall > 0) begin
        out_ready_q <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_q <= 1'b1;
      got = 1'b0;
      while (!got) begin
        @(negedge clk_i);
        got  = out_valid;
        seen = out_data;
        @(posedge clk_i);
      end
      results_seen++;
      if (stim_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = stim_expected.pop_front();
        if (seen.stim_first !== want.stim_first)
          report_mismatch($sformatf("result %0d stim_first got %h want %h",
                                    results_seen, seen.stim_first, want.stim_first));
        if (seen.stim_second !== want.stim_second)
          report_mismatch($sformatf("result %0d stim_second got %h want %h",
                                    results_seen, seen.stim_second, want.stim_second));
        if (seen.stim_third !== want.stim_third)
          report_mismatch($sformatf("result %0d stim_third got %h want %h",
                                    results_seen, seen.stim_third, want.stim_third));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("nerve_stimulation_filter_bank_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int   n_directed;
    int   n_setups;
    int   phase_end;
    int   len;
    int   style;
    int   step;
    int   level;
    in_t  w;

    n_setups = 0;

    // Reset values: gains are zero, so every output reads zero. The very first
    // word carries no start flag and must behave as if it did.
    add_typed(16'sh7FFF, 1'b0, 32'd0, 32'd0, 32'd0);
    add_typed(-16'sd32768, 1'b0, 32'd0, 32'd0, 32'd0);
    add_typed(16'sd0, 1'b1, 32'd0, 32'd0, 32'd0);

    // Full-scale coefficients and gains: a full-range step saturates high,
    // the full-range step back saturates low on every output.
    add_cfg(REG_ALPHA_FIRST, 32'h0000_FFFF);
    add_cfg(REG_ALPHA_SECOND, 32'h0000_FFFF);
    add_cfg(REG_ALPHA_THIRD, 32'h0000_FFFF);
    add_cfg(REG_GAIN_FIRST, 32'hFFFF_FFFF);
    add_cfg(REG_GAIN_SECOND, 32'hFFFF_FFFF);
    add_cfg(REG_GAIN_THIRD, 32'hFFFF_FFFF);
    add_cfg(REG_ABS_MODE, 32'd0);
    add_cfg(REG_UNMAPPED, 32'hFFFF_FFFF);  // must not alias any register
    add_typed(16'sh7FFF, 1'b1, STIM_MAX, STIM_MAX, STIM_MAX);
    add_typed(-16'sd32768, 1'b0, STIM_MIN, STIM_MIN, STIM_MIN);
    add_word(-16'sd32768, 1'b0);  // zero slew: second output takes the positive sign
    add_word(16'sd1, 1'b0);

    // Abs mode: the same swing saturates high on all three outputs.
    add_cfg(REG_ABS_MODE, 32'd1);
    add_typed(16'sh7FFF, 1'b1, STIM_MAX, STIM_MAX, STIM_MAX);
    add_typed(-16'sd32768, 1'b0, STIM_MAX, STIM_MAX, STIM_MAX);

    // Zero coefficients: filters hold their cleared value whatever comes in.
    add_cfg(REG_ALPHA_FIRST, 32'd0);
    add_cfg(REG_ALPHA_SECOND, 32'd0);
    add_cfg(REG_ALPHA_THIRD, 32'd0);
    add_cfg(REG_ABS_MODE, 32'd0);
    add_typed(16'sh7FFF, 1'b1, 32'd0, 32'd0, 32'd0);
    add_typed(-16'sd32768, 1'b0, 32'd0, 32'd0, 32'd0);
    add_typed(16'sd12345, 1'b0, 32'd0, 32'd0, 32'd0);

    // Unity gains with mixed coefficients; a restart at the end.
    add_cfg(REG_ALPHA_FIRST, 32'd32768);
    add_cfg(REG_ALPHA_SECOND, 32'd65535);
    add_cfg(REG_ALPHA_THIRD, 32'd1);
    add_cfg(REG_GAIN_FIRST, 32'h0100_0000);
    add_cfg(REG_GAIN_SECOND, 32'h0100_0000);
    add_cfg(REG_GAIN_THIRD, 32'h0100_0000);
    add_word(16'sd100, 1'b1);
    add_word(16'sd350, 1'b0);
    add_word(16'sd350, 1'b0);
    add_word(-16'sd200, 1'b0);
    add_word(-16'sd32768, 1'b0);
    add_word(16'sh7FFF, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; registers change only with the block drained.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_block();
        write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].stim);
      end
    end
    n_directed = words_sent;

    // Random part: each phase drains, loads a fresh setup, picks idle
    // behavior, then streams whole waveforms with random content.
    level = 0;
    while (words_sent < TOTAL_WORDS) begin
      settle_block();
      write_register(REG_ALPHA_FIRST, pick_alpha());
      write_register(REG_ALPHA_SECOND, pick_alpha());
      write_register(REG_ALPHA_THIRD, pick_alpha());
      write_register(REG_GAIN_FIRST, pick_gain());
      write_register(REG_GAIN_SECOND, pick_gain());
      write_register(REG_GAIN_THIRD, pick_gain());
      write_register(REG_ABS_MODE, $urandom);
      if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, $urandom);
      n_setups++;
      tx_idle   = idle_mode_e'($urandom_range(0, 2));
      rx_idle   = idle_mode_e'($urandom_range(0, 2));
      phase_end = words_sent + int'($urandom_range(60, 180));

      while (words_sent < phase_end && words_sent < TOTAL_WORDS) begin
        len   = $urandom_range(4, 40);
        style = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0:       step = 8;
          1:       step = 256;
          default: step = 4096;
        endcase
        level = 0;
        for (int k = 0; k < len; k++) begin
          if (style == 3) begin
            // Noise: any pattern, stray start flags.
            w.grad_sample    = 16'($urandom);
            w.waveform_start = ($urandom_range(0, 7) == 0);
          end else begin
            // Well-formed waveform: starts flagged, then a bounded random walk.
            level += int'($urandom_range(0, 2 * step)) - step;
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            w.grad_sample    = 16'(level);
            w.waveform_start = (k == 0);
          end
          send_word(w, 1'b0, '0);
        end
      end
    end

    settle_block();
    repeat (16) @(posedge clk_i);
    if (stim_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", stim_expected.size()));

    $display("Run covered %0d words (%0d from the directed table) over %0d random setups,",
             words_sent, n_directed, n_setups);
    $display("%0d results compared, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("nerve_stimulation_filter_bank_core verification clean");
    end else begin
      $display("nerve_stimulation_filter_bank_core verification failed");
    end
    $finish;
  end

endmodule
